// ===== hdl/nfpe_pkg.sv =====
`default_nettype none

package nfpe_pkg;

    localparam int unsigned SUM_W = 20;
    localparam int unsigned POS_W = 7;
    localparam int unsigned BYTE_W = 8;

    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_G      = 8'h47;
    localparam logic [BYTE_W-1:0] CH_P      = 8'h50;
    localparam logic [BYTE_W-1:0] CH_V      = 8'h56;
    localparam logic [BYTE_W-1:0] CH_T      = 8'h54;
    localparam logic [BYTE_W-1:0] CH_A      = 8'h41;
    localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2e;
    localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2d;
    localparam logic [SUM_W-1:0]  CH_ZERO   = 20'd48;

    localparam logic [POS_W-1:0] POS_ABORT = 7'd83;
    localparam logic [POS_W-1:0] POS_MAX   = 7'd127;

    localparam logic [SUM_W-1:0] W_100000 = 20'd100000;
    localparam logic [SUM_W-1:0] W_10000  = 20'd10000;
    localparam logic [SUM_W-1:0] W_1000   = 20'd1000;
    localparam logic [SUM_W-1:0] W_100    = 20'd100;
    localparam logic [SUM_W-1:0] W_10     = 20'd10;
    localparam logic [SUM_W-1:0] W_1      = 20'd1;

    typedef enum logic [1:0] {
        SK_NONE = 2'd0,
        SK_GGA  = 2'd1,
        SK_VTG  = 2'd2
    } sent_kind_t;

    typedef enum logic [2:0] {
        FK_HOURS    = 3'd0,
        FK_MINUTES  = 3'd1,
        FK_SECONDS  = 3'd2,
        FK_COURSE   = 3'd3,
        FK_SPEED    = 3'd4,
        FK_ALTITUDE = 3'd5
    } field_kind_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        sent_kind_t       kind;
        logic [SUM_W-1:0] sum;
    } parse_state_t;

    typedef struct packed {
        logic             emit;
        field_kind_t      kind;
        logic [SUM_W-1:0] value;
    } parse_result_t;

endpackage

`default_nettype wire

// ===== hdl/nfpe_parse.sv =====
`default_nettype none

module nfpe_parse
    import nfpe_pkg::*;
(
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire parse_state_t      cur,
    output parse_state_t           nxt,
    output parse_result_t          res
);

    logic [POS_W-1:0]   pos0;
    sent_kind_t         kind0;
    sent_kind_t         kind1;
    logic               abort;
    logic               do_load;
    logic               do_add;
    logic               zero_term;
    logic [SUM_W-1:0]   weight;
    logic [SUM_W-1:0]   diff;
    logic [2*SUM_W-1:0] prod;
    logic [SUM_W-1:0]   term;
    logic [SUM_W-1:0]   sum1;
    logic [POS_W-1:0]   pos1;
    logic               emit;
    field_kind_t        fkind;

    always_comb
    begin
        pos0      = (rx_byte == CH_DOLLAR) ? '0 : cur.pos;
        kind0     = (rx_byte == CH_DOLLAR) ? SK_NONE : cur.kind;
        kind1     = kind0;
        abort     = 1'b0;
        do_load   = 1'b0;
        do_add    = 1'b0;
        zero_term = 1'b0;
        weight    = W_1;
        emit      = 1'b0;
        fkind     = FK_HOURS;

        // header check
        case (pos0)
            7'd1:
            begin
                if (rx_byte != CH_G)
                begin
                    abort = 1'b1;
                    kind1 = SK_NONE;
                end
            end
            7'd2:
            begin
                if (rx_byte != CH_P)
                begin
                    abort = 1'b1;
                    kind1 = SK_NONE;
                end
            end
            7'd3:
            begin
                if (rx_byte == CH_V)
                    kind1 = SK_VTG;
                else if (rx_byte == CH_G)
                    kind1 = SK_GGA;
                else
                begin
                    abort = 1'b1;
                    kind1 = SK_NONE;
                end
            end
            7'd4:
            begin
                if (!((rx_byte == CH_T && kind0 == SK_VTG) ||
                      (rx_byte == CH_G && kind0 == SK_GGA)))
                begin
                    abort = 1'b1;
                    kind1 = SK_NONE;
                end
            end
            7'd5:
            begin
                if (!((rx_byte == CH_G && kind0 == SK_VTG) ||
                      (rx_byte == CH_A && kind0 == SK_GGA)))
                begin
                    abort = 1'b1;
                    kind1 = SK_NONE;
                end
            end
            default:
            begin
            end
        endcase

        // field positions
        if (kind1 == SK_GGA)
        begin
            case (pos0) inside
                7'd7, 7'd9, 7'd11:
                begin
                    do_load = 1'b1;
                    weight  = W_10;
                end
                7'd8, 7'd10, 7'd12:
                begin
                    do_add = 1'b1;
                    emit   = 1'b1;
                    fkind  = (pos0 == 7'd8) ? FK_HOURS :
                             (pos0 == 7'd10) ? FK_MINUTES : FK_SECONDS;
                end
                7'd51:
                begin
                    do_load   = 1'b1;
                    weight    = W_100000;
                    zero_term = (rx_byte == CH_MINUS);
                end
                7'd52:
                begin
                    do_add = 1'b1;
                    weight = W_10000;
                end
                7'd53:
                begin
                    do_add = 1'b1;
                    weight = W_1000;
                end
                7'd54:
                begin
                    do_add = 1'b1;
                    weight = W_100;
                end
                7'd55:
                begin
                    do_add = 1'b1;
                    weight = W_10;
                end
                7'd56:
                begin
                    if (rx_byte != CH_DOT)
                        abort = 1'b1;
                end
                7'd57:
                begin
                    do_add = 1'b1;
                    emit   = 1'b1;
                    fkind  = FK_ALTITUDE;
                end
                default:
                begin
                end
            endcase
        end
        else if (kind1 == SK_VTG)
        begin
            case (pos0) inside
                7'd7:
                begin
                    do_load = 1'b1;
                    weight  = W_1000;
                end
                7'd8, 7'd27:
                begin
                    do_add = 1'b1;
                    weight = W_100;
                end
                7'd9, 7'd28:
                begin
                    do_add = 1'b1;
                    weight = W_10;
                end
                7'd10, 7'd29:
                begin
                    if (rx_byte != CH_DOT)
                        abort = 1'b1;
                end
                7'd11:
                begin
                    do_add = 1'b1;
                    emit   = 1'b1;
                    fkind  = FK_COURSE;
                end
                7'd25:
                begin
                    do_load = 1'b1;
                    weight  = W_10000;
                end
                7'd26:
                begin
                    do_add = 1'b1;
                    weight = W_1000;
                end
                7'd30:
                begin
                    do_add = 1'b1;
                    emit   = 1'b1;
                    fkind  = FK_SPEED;
                end
                default:
                begin
                end
            endcase
        end

        diff = {{(SUM_W-BYTE_W){1'b0}}, rx_byte} - CH_ZERO;
        prod = {{SUM_W{1'b0}}, diff} * {{SUM_W{1'b0}}, weight};
        term = zero_term ? '0 : prod[SUM_W-1:0];

        if (do_load)
            sum1 = term;
        else if (do_add)
            sum1 = cur.sum + term;
        else
            sum1 = cur.sum;

        pos1 = abort ? POS_ABORT : pos0;

        nxt.pos  = (pos1 < POS_MAX) ? pos1 + 7'd1 : pos1;
        nxt.kind = kind1;
        nxt.sum  = sum1;

        res.emit  = emit;
        res.kind  = fkind;
        res.value = sum1;
    end

endmodule

`default_nettype wire

// ===== hdl/nmea_fixed_position_field_extractor_core.sv =====
// channel | direction | tdata                     | tuser
// s_*     | in        | [7:0] rx_byte             | -
// m_*     | out       | [19:0] field_value, pad 0 | [2:0] field_kind
//
// one byte a cycle sustained unless a stalled result holds an emitting byte;
// a byte is registered in the input register, then the parser and state update
// run in a single pass into the result register, which drives m_tvalid
// rst_n clears position, sentence type, running sum and both valid flags
// a stalled result holds the input register only when that byte also emits;
// bytes that emit nothing keep flowing
`default_nettype none

module nmea_fixed_position_field_extractor_core
    import nfpe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [19:0] field_value, [23:20] zero
    output logic [2:0]       m_tuser    // [2:0] field_kind
);

    logic                in_valid_reg;
    logic [BYTE_W-1:0]   in_byte_reg;
    parse_state_t        state_reg;
    parse_state_t        state_next;
    parse_result_t       res;
    logic                out_valid_reg;
    field_kind_t         out_kind_reg;
    logic [SUM_W-1:0]    out_value_reg;
    logic                out_free;
    logic                advance;

    nfpe_parse u_parse
    (
        .rx_byte (in_byte_reg),
        .cur     (state_reg),
        .nxt     (state_next),
        .res     (res)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!res.emit || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg.pos  <= '0;
            state_reg.kind <= SK_NONE;
            state_reg.sum  <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                state_reg <= state_next;
            if (advance && res.emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata;
        if (advance && res.emit)
        begin
            out_kind_reg  <= res.kind;
            out_value_reg <= res.value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_value_reg};
    assign m_tuser  = out_kind_reg;

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("input register lost a stalled byte");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.emit && out_valid_reg) |-> m_tready)
        else $error("result register overwritten while full");

    a_pos_moves: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (state_reg.pos != '0))
        else $error("position not advanced after a byte");

    a_alt_gga: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.emit && res.kind == FK_ALTITUDE) |-> (state_reg.kind == SK_GGA))
        else $error("altitude emitted outside a GGA sentence");

endmodule

`default_nettype wire
